// ===== rtl/dtbg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtbg_pkg
// Shared types and constants of the dual-tone burst generator.
// ----------------------------------------------------------------------------
package dtbg_pkg;

   // Register map of the configuration port
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TONE_A_STEP     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TONE_B_STEP     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLAY_SAMPLES    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SILENCE_SAMPLES = 2'd3;

   localparam int unsigned PHASE_BITS = 32;
   localparam int unsigned COUNT_BITS = 24;
   localparam int unsigned POS_BITS   = 25;
   localparam int unsigned OUT_BITS   = 16;

   // Per-word flags carried from the sequencer stage to the output stage
   typedef struct packed {
      logic tone;
      logic last;
      logic idle;
   } word_flags_type;

endpackage : dtbg_pkg
`default_nettype wire

// ===== rtl/dtbg_sine_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtbg_sine_rom
// Two-port synchronous sine ROM with a registered read. Contents are built
// at elaboration from a fixed-point quarter-wave polynomial.
// ----------------------------------------------------------------------------
module dtbg_sine_rom
   import dtbg_pkg::*;
#(
   parameter int unsigned SINE_TABLE_DEPTH = 1024,
   parameter int unsigned SAMPLE_BITS      = 16,
   parameter int unsigned ADDR_BITS        = 10
) (
   input  wire                          clock,
   input  wire                          rd_en,
   input  wire  [ADDR_BITS-1:0]         rd_addr_a,
   input  wire  [ADDR_BITS-1:0]         rd_addr_b,
   output logic signed [SAMPLE_BITS-1:0] rd_data_a,
   output logic signed [SAMPLE_BITS-1:0] rd_data_b
);

   typedef logic signed [SAMPLE_BITS-1:0] rom_word_type;
   typedef rom_word_type rom_array_type [SINE_TABLE_DEPTH];

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   function automatic rom_array_type build_rom();
      rom_array_type tbl;
      logic [63:0]   k;
      logic [63:0]   t;
      logic [63:0]   quad;
      logic [63:0]   r;
      logic [63:0]   x;
      logic [63:0]   x2;
      logic [63:0]   q;
      logic [63:0]   s;
      logic [63:0]   amp;
      logic [63:0]   v;
      amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
      for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
         k    = 64'(i);
         t    = (k << 32) / 64'(SINE_TABLE_DEPTH);
         quad = (t >> 30) & 64'd3;
         r    = t & (Q30_ONE - 64'd1);
         if (quad[0]) begin
            r = Q30_ONE - r;
         end
         x  = (r * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         q  = Q30_ONE - x2 / 64'd72;
         q  = Q30_ONE - ((x2 * q) >> 30) / 64'd42;
         q  = Q30_ONE - ((x2 * q) >> 30) / 64'd20;
         q  = Q30_ONE - ((x2 * q) >> 30) / 64'd6;
         s  = (x * q) >> 30;
         v  = (s * amp + (64'd1 << 29)) >> 30;
         if (v > amp) begin
            v = amp;
         end
         tbl[i] = quad[1] ? rom_word_type'(-v) : rom_word_type'(v);
      end
      return tbl;
   endfunction

   localparam rom_array_type SINE_ROM = build_rom();

   rom_word_type data_a_ff;
   rom_word_type data_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= SINE_ROM[rd_addr_a];
         data_b_ff <= SINE_ROM[rd_addr_b];
      end
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule : dtbg_sine_rom
`default_nettype wire

// ===== rtl/dtbg_mix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtbg_mix
// Average the two sine words, scale to Q1.15, force zero outside the tone
// part and hold the result word in the output register.
// ----------------------------------------------------------------------------
module dtbg_mix
   import dtbg_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           s1_valid,
   input  word_flags_type                s1_flags,
   input  wire  signed [SAMPLE_BITS-1:0] sine_a,
   input  wire  signed [SAMPLE_BITS-1:0] sine_b,
   output logic                          s2_ready,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic signed [OUT_BITS-1:0]    rsp_sample,
   output logic                          rsp_in_tone,
   output logic                          rsp_last,
   output logic                          rsp_idle
);

   localparam int unsigned SHL = (SAMPLE_BITS < OUT_BITS) ? OUT_BITS - SAMPLE_BITS : 0;
   localparam int unsigned SHR = (SAMPLE_BITS > OUT_BITS) ? SAMPLE_BITS - OUT_BITS : 0;

   logic signed [SAMPLE_BITS:0]   sum;
   logic signed [SAMPLE_BITS-1:0] avg;
   logic signed [31:0]            avg_ext;
   logic signed [31:0]            scaled;
   logic signed [OUT_BITS-1:0]    sample_in;

   logic                          valid_ff;
   logic signed [OUT_BITS-1:0]    sample_ff;
   word_flags_type                flags_ff;

   always_comb begin
      sum     = {sine_a[SAMPLE_BITS-1], sine_a} + {sine_b[SAMPLE_BITS-1], sine_b};
      avg     = sum[SAMPLE_BITS:1];
      avg_ext = 32'(avg);
      scaled  = (avg_ext <<< SHL) >>> SHR;
      // zero outside the tone part
      sample_in = s1_flags.tone ? scaled[OUT_BITS-1:0] : '0;
   end

   assign s2_ready = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (s2_ready) begin
         valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid) begin
         sample_ff <= sample_in;
         flags_ff  <= s1_flags;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_sample  = sample_ff;
   assign rsp_in_tone = flags_ff.tone;
   assign rsp_last    = flags_ff.last;
   assign rsp_idle    = flags_ff.idle;

endmodule : dtbg_mix
`default_nettype wire

// ===== rtl/dual_tone_burst_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dual_tone_burst_generator
// One burst of a two-tone signal followed by silence, one sample per word.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the req_ channel (req_valid high, req_stall low) yields one
//   result word on the rsp_ channel. req_restart = 1 starts a new burst with
//   both phases cleared; that word is burst sample zero.
//   During the first play_samples words of a burst the sample is the average
//   of two sine ROM lookups; the next silence_samples words carry zero. The
//   final word of the burst has rsp_last set; afterwards rsp_idle is set and
//   the sample is zero until the next restart.
//   Program the four registers through csr_write / csr_index / csr_wdata
//   only while no word is in flight.
// Timing:
//   From acceptance to rsp_valid a word passes the ROM stage (sequencer
//   update and the registered sine ROM read) and then the mix and output
//   register. Throughput is one word per clock while the receiver does not
//   stall, set by the position/phase update per word and the two-port sine ROM.
//   When the receiver stalls, the output register holds its word; the ROM
//   stage takes one more word only if empty, and req_stall is high while it is full.
// Reset:
//   Synchronous reset clears the registers to zero, the phases and position
//   to zero and leaves the block idle until the first restart.
// ----------------------------------------------------------------------------
module dual_tone_burst_generator
   import dtbg_pkg::*;
#(
   parameter int unsigned SINE_TABLE_DEPTH = 1024,
   parameter int unsigned SAMPLE_BITS      = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   // configuration
   input  wire                         csr_write,
   input  wire  [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [CSR_DATA_BITS-1:0]    csr_wdata,
   // request words
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire                         req_restart,
   // result words
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic signed [OUT_BITS-1:0]  rsp_sample,
   output logic                        rsp_in_tone,
   output logic                        rsp_last,
   output logic                        rsp_idle
);

   localparam int unsigned ADDR_BITS = $clog2(SINE_TABLE_DEPTH);

   // configuration registers
   logic [PHASE_BITS-1:0] tone_a_step_ff;
   logic [PHASE_BITS-1:0] tone_b_step_ff;
   logic [COUNT_BITS-1:0] play_samples_ff;
   logic [COUNT_BITS-1:0] silence_samples_ff;

   // burst state
   logic [POS_BITS-1:0]   pos_ff;
   logic [POS_BITS-1:0]   pos_in;
   logic [PHASE_BITS-1:0] phase_a_ff;
   logic [PHASE_BITS-1:0] phase_a_in;
   logic [PHASE_BITS-1:0] phase_b_ff;
   logic [PHASE_BITS-1:0] phase_b_in;
   logic                  done_ff;
   logic                  done_in;

   // ROM stage
   logic                  s1_valid_ff;
   word_flags_type        s1_flags_ff;
   word_flags_type        flags_in;
   logic                  s1_ready;
   logic                  s2_ready;
   logic                  req_accept;

   logic [POS_BITS-1:0]   total;
   logic [POS_BITS-1:0]   pos_cur;
   logic [PHASE_BITS-1:0] phase_a_cur;
   logic [PHASE_BITS-1:0] phase_b_cur;
   logic                  done_cur;
   logic [63:0]           prod_a;
   logic [63:0]           prod_b;
   logic [ADDR_BITS-1:0]  addr_a;
   logic [ADDR_BITS-1:0]  addr_b;

   logic signed [SAMPLE_BITS-1:0] sine_a;
   logic signed [SAMPLE_BITS-1:0] sine_b;

   // ---------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_a_step_ff     <= '0;
         tone_b_step_ff     <= '0;
         play_samples_ff    <= '0;
         silence_samples_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TONE_A_STEP:     tone_a_step_ff     <= csr_wdata[PHASE_BITS-1:0];
            CSR_TONE_B_STEP:     tone_b_step_ff     <= csr_wdata[PHASE_BITS-1:0];
            CSR_PLAY_SAMPLES:    play_samples_ff    <= csr_wdata[COUNT_BITS-1:0];
            CSR_SILENCE_SAMPLES: silence_samples_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sequencer: advance the burst once per accepted word
   // ---------------------------------------------------------------------
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;

   always_comb begin
      total = {1'b0, play_samples_ff} + {1'b0, silence_samples_ff};

      // restart clears position and phases for this very word
      pos_cur     = req_restart ? '0 : pos_ff;
      phase_a_cur = req_restart ? '0 : phase_a_ff;
      phase_b_cur = req_restart ? '0 : phase_b_ff;
      done_cur    = req_restart ? 1'b0 : done_ff;

      // drop into idle when the position already sits past the burst
      if (!done_cur && pos_cur >= total) begin
         done_cur = 1'b1;
      end

      flags_in   = '0;
      pos_in     = pos_cur;
      phase_a_in = phase_a_cur;
      phase_b_in = phase_b_cur;
      done_in    = done_cur;

      if (done_cur) begin
         flags_in.idle = 1'b1;
      end else begin
         if (pos_cur < {1'b0, play_samples_ff}) begin
            flags_in.tone = 1'b1;
            phase_a_in    = phase_a_cur + tone_a_step_ff;
            phase_b_in    = phase_b_cur + tone_b_step_ff;
         end
         if (({1'b0, pos_cur} + 26'd1) == {1'b0, total}) begin
            flags_in.last = 1'b1;
            done_in       = 1'b1;
         end
         pos_in = pos_cur + 25'd1;
      end

      // ROM address: floor(phase * depth / 2^32)
      prod_a = 64'(phase_a_cur) * 64'(SINE_TABLE_DEPTH);
      prod_b = 64'(phase_b_cur) * 64'(SINE_TABLE_DEPTH);
      addr_a = prod_a[PHASE_BITS +: ADDR_BITS];
      addr_b = prod_b[PHASE_BITS +: ADDR_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         phase_a_ff <= '0;
         phase_b_ff <= '0;
         done_ff    <= 1'b1;
      end else if (req_accept) begin
         pos_ff     <= pos_in;
         phase_a_ff <= phase_a_in;
         phase_b_ff <= phase_b_in;
         done_ff    <= done_in;
      end
   end

   // hold the ROM stage while the output register is full and stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_flags_ff <= flags_in;
      end
   end

   dtbg_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SAMPLE_BITS      (SAMPLE_BITS),
      .ADDR_BITS        (ADDR_BITS)
   ) u_sine_rom (
      .clock     (clock),
      .rd_en     (req_accept),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (sine_a),
      .rd_data_b (sine_b)
   );

   dtbg_mix #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mix (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid_ff),
      .s1_flags    (s1_flags_ff),
      .sine_a      (sine_a),
      .sine_b      (sine_b),
      .s2_ready    (s2_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .rsp_in_tone (rsp_in_tone),
      .rsp_last    (rsp_last),
      .rsp_idle    (rsp_idle)
   );

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_idle) |-> (rsp_sample == '0 && !rsp_in_tone && !rsp_last))
      else $error("idle word carries a nonzero field");

   a_silence_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_tone) |-> (rsp_sample == '0))
      else $error("sample outside the tone part is nonzero");

   a_last_ends_burst : assert property (@(posedge clock) disable iff (reset)
      (req_accept && flags_in.last) |=> done_ff)
      else $error("burst still running after its last word");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_flags_ff)))
      else $error("ROM stage word lost while output stalled");

endmodule : dual_tone_burst_generator
`default_nettype wire
